// ===== sv/banked_register_mode_switch_top_defines.svh =====
// Assertion macros shared by the banked register mode switch design.
`ifndef BANKED_REGISTER_MODE_SWITCH_TOP_DEFINES_SVH
`define BANKED_REGISTER_MODE_SWITCH_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BRMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BRMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/brms_pkg.sv =====
// Types, constants and decode functions shared by the banked register mode switch.
package brms_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned MODE_W  = 5;
   localparam int unsigned IDX_W   = 4;
   localparam int unsigned NREGS   = 16;
   localparam int unsigned NBANK3  = 4;
   localparam int unsigned FIQ_W   = 8;
   localparam int unsigned FIQ_SWAP_BASE  = 8;
   localparam int unsigned FIQ_SWAP_COUNT = 5;

   localparam logic [IDX_W-1:0] REG_SP = 4'd13;
   localparam logic [IDX_W-1:0] REG_LR = 4'd14;

   localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
   localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
   localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
   localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
   localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
   localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
   localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

   localparam logic [DATA_W-1:0] SPSR_RESET = 32'h0000_001F;

   localparam logic [2:0] FIQ_SLOT_SP   = 3'd5;
   localparam logic [2:0] FIQ_SLOT_LR   = 3'd6;
   localparam logic [2:0] FIQ_SLOT_SPSR = 3'd7;

   localparam logic [1:0] B3_SLOT_SP   = 2'd0;
   localparam logic [1:0] B3_SLOT_LR   = 2'd1;
   localparam logic [1:0] B3_SLOT_SPSR = 2'd2;

   typedef enum logic [1:0] {
      OP_SWITCH = 2'd0,
      OP_READ   = 2'd1,
      OP_WRITE  = 2'd2,
      OP_WSPSR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_SAVE,
      ST_LOAD,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic latch;
      logic access;
      logic save;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] sel;
   } bank3_type;

   function automatic bank3_type bank3_decode(input logic [MODE_W-1:0] mode);
      bank3_type res;
      res = '0;
      unique case (mode)
         MODE_IRQ: begin
            res.hit = 1'b1;
            res.sel = 2'd0;
         end
         MODE_SVC: begin
            res.hit = 1'b1;
            res.sel = 2'd1;
         end
         MODE_ABT: begin
            res.hit = 1'b1;
            res.sel = 2'd2;
         end
         MODE_UND: begin
            res.hit = 1'b1;
            res.sel = 2'd3;
         end
         default: begin
            res = '0;
         end
      endcase
      return res;
   endfunction

endpackage

// ===== sv/banked_register_mode_switch_top.sv =====
// Top level of the banked register file with processor mode switching.
//
//   Channel  Handshake             Signals
//   request  start & !busy         req_operation req_reg_index req_write_data req_new_mode
//   response rsp_valid, one cycle  rsp_read_data rsp_old_mode rsp_current_mode
//                                  rsp_saved_status
//
// A read or write transaction runs one access step and then the response cycle.
// A mode switch runs a save step, a load step and then the response cycle.
// A new transaction is accepted in the response cycle of the previous one.
// Synchronous reset clears the registers and banks, sets the SPSR to SPSR_RESET and puts the mode in system mode.
// The response cannot be stalled; it is valid for exactly one cycle.
`include "banked_register_mode_switch_top_defines.svh"

module banked_register_mode_switch_top
   import brms_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic [IDX_W-1:0]    req_reg_index,
   input  logic [DATA_W-1:0]   req_write_data,
   input  logic [MODE_W-1:0]   req_new_mode,
   output logic                rsp_valid,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [MODE_W-1:0]   rsp_old_mode,
   output logic [MODE_W-1:0]   rsp_current_mode,
   output logic [DATA_W-1:0]   rsp_saved_status
);

   cmd_type cmd;
   logic    item_switch;

   brms_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   brms_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .req_new_mode   (req_new_mode),
      .item_switch    (item_switch),
      .read_data      (rsp_read_data),
      .old_mode       (rsp_old_mode),
      .current_mode   (rsp_current_mode),
      .saved_status   (rsp_saved_status)
   );

   `BRMS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_valid, "Accepted transaction did not raise busy.")
   `BRMS_ASSERT_NOW(a_access_mode, rsp_valid && !item_switch, rsp_old_mode == rsp_current_mode, "Access transaction changed the mode.")
   `BRMS_ASSERT_NOW(a_read_zero, rsp_valid && item_switch, rsp_read_data == '0, "Mode switch returned nonzero read data.")
   `BRMS_ASSERT_NEXT(a_one_strobe, rsp_valid, !rsp_valid, "Response strobe lasted more than one cycle.")

endmodule

// ===== sv/brms_ctrl.sv =====
// Controller state machine that sequences access, save and load steps.
module brms_ctrl
   import brms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_operation,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE, ST_RESPOND: begin
            busy      = 1'b0;
            rsp_valid = (state_ff == ST_RESPOND);
            if (start) begin
               cmd.latch = 1'b1;
               if (op_type'(req_operation) == OP_SWITCH) begin
                  state_in = ST_SAVE;
               end else begin
                  state_in = ST_ACCESS;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_SAVE: begin
            cmd.save = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_RESPOND;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/brms_dpath.sv =====
// Datapath holding the visible registers, the shadow banks and the result registers.
module brms_dpath
   import brms_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [1:0]          req_operation,
   input  logic [IDX_W-1:0]    req_reg_index,
   input  logic [DATA_W-1:0]   req_write_data,
   input  logic [MODE_W-1:0]   req_new_mode,
   output logic                item_switch,
   output logic [DATA_W-1:0]   read_data,
   output logic [MODE_W-1:0]   old_mode,
   output logic [MODE_W-1:0]   current_mode,
   output logic [DATA_W-1:0]   saved_status
);

   op_type              op_ff, op_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [MODE_W-1:0]   nm_ff, nm_in;
   logic [MODE_W-1:0]   old_ff, old_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [DATA_W-1:0]   spsr_ff, spsr_in;
   logic [DATA_W-1:0]   vis_ff [NREGS];
   logic [DATA_W-1:0]   vis_in [NREGS];
   logic [DATA_W-1:0]   user_ff [2];
   logic [DATA_W-1:0]   user_in [2];
   logic [DATA_W-1:0]   fiq_ff [FIQ_W];
   logic [DATA_W-1:0]   fiq_in [FIQ_W];
   logic [DATA_W-1:0]   b3_ff [NBANK3][3];
   logic [DATA_W-1:0]   b3_in [NBANK3][3];

   bank3_type           save_b3;
   bank3_type           load_b3;

   assign save_b3 = bank3_decode(mode_ff);
   assign load_b3 = bank3_decode(nm_ff);

   always_comb begin
      op_in    = op_ff;
      idx_in   = idx_ff;
      data_in  = data_ff;
      nm_in    = nm_ff;
      old_in   = old_ff;
      rdata_in = rdata_ff;
      mode_in  = mode_ff;
      spsr_in  = spsr_ff;
      vis_in   = vis_ff;
      user_in  = user_ff;
      fiq_in   = fiq_ff;
      b3_in    = b3_ff;

      if (cmd.latch) begin
         op_in    = op_type'(req_operation);
         idx_in   = req_reg_index;
         data_in  = req_write_data;
         nm_in    = req_new_mode;
         old_in   = mode_ff;
         rdata_in = '0;
      end

      if (cmd.access) begin
         case (op_ff)
            OP_READ:  rdata_in = vis_ff[idx_ff];
            OP_WRITE: vis_in[idx_ff] = data_ff;
            OP_WSPSR: spsr_in = data_ff;
            default:  rdata_in = rdata_ff;
         endcase
      end

      if (cmd.save) begin
         if (mode_ff == MODE_USR || mode_ff == MODE_SYS) begin
            user_in[0] = vis_ff[REG_SP];
            user_in[1] = vis_ff[REG_LR];
         end else if (mode_ff == MODE_FIQ) begin
            for (int i = 0; i < FIQ_SWAP_COUNT; i++) begin
               vis_in[IDX_W'(FIQ_SWAP_BASE + i)] = fiq_ff[3'(i)];
               fiq_in[3'(i)]                     = vis_ff[IDX_W'(FIQ_SWAP_BASE + i)];
            end
            fiq_in[FIQ_SLOT_SP]   = vis_ff[REG_SP];
            fiq_in[FIQ_SLOT_LR]   = vis_ff[REG_LR];
            fiq_in[FIQ_SLOT_SPSR] = spsr_ff;
         end else if (save_b3.hit) begin
            b3_in[save_b3.sel][B3_SLOT_SP]   = vis_ff[REG_SP];
            b3_in[save_b3.sel][B3_SLOT_LR]   = vis_ff[REG_LR];
            b3_in[save_b3.sel][B3_SLOT_SPSR] = spsr_ff;
         end
      end

      if (cmd.load) begin
         mode_in = nm_ff;
         if (nm_ff == MODE_USR || nm_ff == MODE_SYS) begin
            vis_in[REG_SP] = user_ff[0];
            vis_in[REG_LR] = user_ff[1];
         end else if (nm_ff == MODE_FIQ) begin
            for (int i = 0; i < FIQ_SWAP_COUNT; i++) begin
               vis_in[IDX_W'(FIQ_SWAP_BASE + i)] = fiq_ff[3'(i)];
               fiq_in[3'(i)]                     = vis_ff[IDX_W'(FIQ_SWAP_BASE + i)];
            end
            vis_in[REG_SP] = fiq_ff[FIQ_SLOT_SP];
            vis_in[REG_LR] = fiq_ff[FIQ_SLOT_LR];
            spsr_in        = fiq_ff[FIQ_SLOT_SPSR];
         end else if (load_b3.hit) begin
            vis_in[REG_SP] = b3_ff[load_b3.sel][B3_SLOT_SP];
            vis_in[REG_LR] = b3_ff[load_b3.sel][B3_SLOT_LR];
            spsr_in        = b3_ff[load_b3.sel][B3_SLOT_SPSR];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SYS;
         spsr_ff <= SPSR_RESET;
         vis_ff  <= '{default: '0};
         user_ff <= '{default: '0};
         fiq_ff  <= '{default: '0};
         b3_ff   <= '{default: '0};
      end else begin
         mode_ff <= mode_in;
         spsr_ff <= spsr_in;
         vis_ff  <= vis_in;
         user_ff <= user_in;
         fiq_ff  <= fiq_in;
         b3_ff   <= b3_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      data_ff  <= data_in;
      nm_ff    <= nm_in;
      old_ff   <= old_in;
      rdata_ff <= rdata_in;
   end

   assign item_switch  = (op_ff == OP_SWITCH);
   assign read_data    = rdata_ff;
   assign old_mode     = old_ff;
   assign current_mode = mode_ff;
   assign saved_status = spsr_ff;

endmodule

// ===== tb/tb_banked_register_mode_switch_top.sv =====
// Self-checking testbench for the banked register file with mode switching.
`timescale 1ns / 100ps

module tb_banked_register_mode_switch_top;
   import brms_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [MODE_W-1:0] old_mode;
      logic [MODE_W-1:0] current_mode;
      logic [DATA_W-1:0] saved_status;
   } mode_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_operation = '0;
   logic [IDX_W-1:0]  req_reg_index = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic [MODE_W-1:0] req_new_mode = '0;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_read_data;
   logic [MODE_W-1:0] rsp_old_mode;
   logic [MODE_W-1:0] rsp_current_mode;
   logic [DATA_W-1:0] rsp_saved_status;

   logic [DATA_W-1:0] regs_q [NREGS];
   logic [DATA_W-1:0] user_bank_q [2];
   logic [DATA_W-1:0] fiq_bank_q [FIQ_W];
   logic [DATA_W-1:0] bank3_q [NBANK3][3];
   logic [MODE_W-1:0] mode_q;
   logic [DATA_W-1:0] spsr_q;

   mode_report_type reports_due [$];
   int sender_idle_pct = 0;
   int mismatch_count = 0;
   int checked_count = 0;
   int cycle_count = 0;
   int op_count [4] = '{0, 0, 0, 0};

   banked_register_mode_switch_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .req_new_mode     (req_new_mode),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_old_mode     (rsp_old_mode),
      .rsp_current_mode (rsp_current_mode),
      .rsp_saved_status (rsp_saved_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int bank3_slot(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_IRQ: return 0;
         MODE_SVC: return 1;
         MODE_ABT: return 2;
         MODE_UND: return 3;
         default: return -1;
      endcase
   endfunction

   function automatic void fiq_swap();
      logic [DATA_W-1:0] held;
      for (int i = 0; i < FIQ_SWAP_COUNT; i++) begin
         held = regs_q[IDX_W'(FIQ_SWAP_BASE + i)];
         regs_q[IDX_W'(FIQ_SWAP_BASE + i)] = fiq_bank_q[3'(i)];
         fiq_bank_q[3'(i)] = held;
      end
   endfunction

   function automatic mode_report_type regfile_apply(input op_type op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [DATA_W-1:0] data,
                                                     input logic [MODE_W-1:0] nm);
      mode_report_type rep;
      int slot;
      rep = '0;
      rep.old_mode = mode_q;
      case (op)
         OP_SWITCH: begin
            slot = bank3_slot(mode_q);
            if (mode_q == MODE_USR || mode_q == MODE_SYS) begin
               user_bank_q[0] = regs_q[REG_SP];
               user_bank_q[1] = regs_q[REG_LR];
            end else if (mode_q == MODE_FIQ) begin
               fiq_swap();
               fiq_bank_q[FIQ_SLOT_SP] = regs_q[REG_SP];
               fiq_bank_q[FIQ_SLOT_LR] = regs_q[REG_LR];
               fiq_bank_q[FIQ_SLOT_SPSR] = spsr_q;
            end else if (slot >= 0) begin
               bank3_q[slot[1:0]][B3_SLOT_SP] = regs_q[REG_SP];
               bank3_q[slot[1:0]][B3_SLOT_LR] = regs_q[REG_LR];
               bank3_q[slot[1:0]][B3_SLOT_SPSR] = spsr_q;
            end
            slot = bank3_slot(nm);
            if (nm == MODE_USR || nm == MODE_SYS) begin
               regs_q[REG_SP] = user_bank_q[0];
               regs_q[REG_LR] = user_bank_q[1];
            end else if (nm == MODE_FIQ) begin
               fiq_swap();
               regs_q[REG_SP] = fiq_bank_q[FIQ_SLOT_SP];
               regs_q[REG_LR] = fiq_bank_q[FIQ_SLOT_LR];
               spsr_q = fiq_bank_q[FIQ_SLOT_SPSR];
            end else if (slot >= 0) begin
               regs_q[REG_SP] = bank3_q[slot[1:0]][B3_SLOT_SP];
               regs_q[REG_LR] = bank3_q[slot[1:0]][B3_SLOT_LR];
               spsr_q = bank3_q[slot[1:0]][B3_SLOT_SPSR];
            end
            mode_q = nm;
         end
         OP_READ: begin
            rep.read_data = regs_q[idx];
         end
         OP_WRITE: begin
            regs_q[idx] = data;
         end
         default: begin
            spsr_q = data;
         end
      endcase
      rep.current_mode = mode_q;
      rep.saved_status = spsr_q;
      return rep;
   endfunction

   task automatic send_item(input op_type op, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data, input logic [MODE_W-1:0] nm);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_reg_index <= idx;
      req_write_data <= data;
      req_new_mode <= nm;
      do @(posedge clock); while (busy !== 1'b0);
      reports_due.push_back(regfile_apply(op, idx, data, nm));
      op_count[op]++;
   endtask

   always @(posedge clock) begin
      mode_report_type got;
      mode_report_type want;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_read_data, rsp_old_mode, rsp_current_mode, rsp_saved_status};
         if (reports_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("Unexpected response: read_data %h old_mode %h mode %h spsr %h",
                        got.read_data, got.old_mode, got.current_mode, got.saved_status);
         end else begin
            want = reports_due.pop_front();
            checked_count++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("Item %0d exp/act: data %h/%h old %h/%h mode %h/%h spsr %h/%h",
                           checked_count,
                           want.read_data, got.read_data, want.old_mode, got.old_mode,
                           want.current_mode, got.current_mode,
                           want.saved_status, got.saved_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_plain_access();
      send_item(OP_WRITE, 4'd0, 32'hFFFF_FFFF, 5'h00);
      send_item(OP_WRITE, 4'd15, 32'h8000_0001, 5'h1F);
      send_item(OP_READ, 4'd0, 32'h0, 5'h00);
      send_item(OP_READ, 4'd15, 32'hFFFF_FFFF, 5'h1F);
      send_item(OP_WSPSR, 4'd15, 32'hFFFF_FFFF, 5'h00);
   endtask

   task automatic test_fiq_exchange();
      send_item(OP_WRITE, 4'd8, 32'h1111_1111, MODE_FIQ);
      send_item(OP_WRITE, REG_SP, 32'h1313_1313, MODE_FIQ);
      send_item(OP_SWITCH, 4'd8, 32'h0, MODE_FIQ);
      send_item(OP_READ, 4'd8, 32'h0, MODE_FIQ);
      send_item(OP_WRITE, 4'd12, 32'hC0C0_C0C0, MODE_FIQ);
      send_item(OP_SWITCH, 4'd12, 32'h0, MODE_USR);
   endtask

   task automatic test_three_bank_modes();
      logic [MODE_W-1:0] modes [NBANK3];
      modes = '{MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND};
      for (int i = 0; i < NBANK3; i++) begin
         send_item(OP_SWITCH, REG_LR, $urandom, modes[2'(i)]);
         send_item(OP_WSPSR, REG_LR, $urandom, modes[2'(i)]);
      end
      send_item(OP_SWITCH, REG_SP, 32'h0, MODE_UND);
   endtask

   task automatic test_unknown_modes();
      send_item(OP_SWITCH, 4'd0, 32'h0, 5'h00);
      send_item(OP_WSPSR, 4'd0, 32'h5A5A_A5A5, 5'h00);
      send_item(OP_SWITCH, 4'd0, 32'h0, 5'h15);
      send_item(OP_SWITCH, 4'd0, 32'h0, MODE_SYS);
   endtask

   task automatic test_random_traffic(input int items, input int idle_pct);
      logic [MODE_W-1:0] known [7];
      int roll;
      op_type op;
      logic [IDX_W-1:0] idx;
      logic [DATA_W-1:0] data;
      logic [MODE_W-1:0] nm;
      known = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};
      sender_idle_pct = idle_pct;
      repeat (items) begin
         roll = $urandom_range(99);
         op = roll < 25 ? OP_SWITCH : roll < 60 ? OP_READ : roll < 85 ? OP_WRITE : OP_WSPSR;
         if ($urandom_range(1) != 0)
            idx = IDX_W'($urandom_range(14, 8));
         else
            idx = IDX_W'($urandom_range(15));
         case ($urandom_range(9))
            0: data = '0;
            1: data = '1;
            default: data = $urandom;
         endcase
         if ($urandom_range(9) < 8)
            nm = known[3'($urandom_range(6))];
         else
            nm = MODE_W'($urandom_range(31));
         send_item(op, idx, data, nm);
      end
   endtask

   initial begin
      regs_q = '{default: '0};
      fiq_bank_q = '{default: '0};
      bank3_q = '{default: '0};
      user_bank_q = '{'0, '0};
      mode_q = MODE_SYS;
      spsr_q = SPSR_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_plain_access();
      test_fiq_exchange();
      test_three_bank_modes();
      test_unknown_modes();
      // The response side cannot be stalled, so only the sender idles.
      test_random_traffic(130, 0);
      test_random_traffic(140, 63);
      test_random_traffic(130, 33);

      start <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      mismatch_count += reports_due.size();

      $display("Ran %0d mode switches, %0d reads, %0d register writes and %0d SPSR writes.",
               op_count[OP_SWITCH], op_count[OP_READ], op_count[OP_WRITE],
               op_count[OP_WSPSR]);
      $display("Checked %0d responses with the sender busy, and idle 63 and 33 percent.",
               checked_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
